/* sv/srfp_pkg.sv */
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants for the scale reading frame parser
// Character codes, byte classes, request and result records.
// ----------------------------------------------------------------------------
package srfp_pkg;

  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChU     = 8'h55;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChLowV  = 8'h76;

  // Frame layout: header, stability char, then the mass field
  localparam int MassStart = 4;
  localparam int FrameExtra = 9;
  localparam int PosW = 5;
  localparam int AccW = 40;
  localparam int MantW = 41;
  localparam int FracW = 4;

  typedef enum logic [2:0] {
    STAB_STABLE    = 3'd0,
    STAB_UNSTABLE  = 3'd1,
    STAB_OVER_HIGH = 3'd2,
    STAB_OVER_LOW  = 3'd3,
    STAB_OTHER     = 3'd4
  } stab_e;

  typedef enum logic [2:0] {
    CLS_SPACE = 3'd0,
    CLS_PLUS  = 3'd1,
    CLS_MINUS = 3'd2,
    CLS_DIGIT = 3'd3,
    CLS_POINT = 3'd4,
    CLS_OTHER = 3'd5
  } byte_cls_e;

  typedef enum logic [1:0] {
    REQ_MASS_FIRST = 2'd0,
    REQ_MASS       = 2'd1,
    REQ_EMIT       = 2'd2
  } req_op_e;

  typedef struct packed {
    req_op_e    op;
    byte_cls_e  cls;
    logic [3:0] digit;
    stab_e      stab;
  } srfp_req_t;

  typedef struct packed {
    logic signed [MantW-1:0] mass_mantissa;
    logic [FracW-1:0]        fraction_digits;
    logic                    mass_valid;
    stab_e                   stability_class;
  } srfp_res_t;

  function automatic stab_e classify_stab(input logic [7:0] b);
    stab_e s;
    s = STAB_OTHER;
    if (b == ChSpace) s = STAB_STABLE;
    else if (b == ChQuery) s = STAB_UNSTABLE;
    else if (b == ChCaret) s = STAB_OVER_HIGH;
    else if (b == ChLowV) s = STAB_OVER_LOW;
    return s;
  endfunction

  function automatic byte_cls_e classify_byte(input logic [7:0] b);
    byte_cls_e c;
    c = CLS_OTHER;
    if (b == ChSpace) c = CLS_SPACE;
    else if (b == ChPlus) c = CLS_PLUS;
    else if (b == ChMinus) c = CLS_MINUS;
    else if (b == ChPoint) c = CLS_POINT;
    else if (b >= ChZero && b <= ChNine) c = CLS_DIGIT;
    return c;
  endfunction

endpackage

/* sv/srfp_fifo.sv */
// ----------------------------------------------------------------------------
// srfp_fifo: small register-based queue
// Push/full on the write side, pop/empty on the read side, DEPTH >= 2.
// ----------------------------------------------------------------------------
module srfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count missed a push");

endmodule

/* sv/srfp_front.sv */
// ----------------------------------------------------------------------------
// srfp_front: byte intake and frame tracking
// Tracks byte position, header and stability char; classifies mass bytes
// and issues parse and emit requests to the back end.
// ----------------------------------------------------------------------------
module srfp_front
  import srfp_pkg::*;
#(
  parameter int MASS_CHARS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic [7:0] rx_byte_i,
  output logic      full_o,
  output logic      req_push_o,
  output srfp_req_t req_o,
  input  logic      req_full_i
);

  localparam logic [PosW-1:0] MassFirst = PosW'(MassStart);
  localparam logic [PosW-1:0] MassEnd   = PosW'(MassStart + MASS_CHARS);
  localparam logic [PosW-1:0] FrameLen  = PosW'(MASS_CHARS + FrameExtra);

  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  logic            hdr_q, hdr_d;
  stab_e           stab_q, stab_d;
  logic            accept, in_mass;

  assign full_o  = req_full_i;
  assign accept  = push_i & ~req_full_i;
  assign pos_inc = pos_q + PosW'(1);
  assign in_mass = (pos_q >= MassFirst) && (pos_q < MassEnd);

  always_comb begin
    pos_d      = pos_q;
    hdr_d      = hdr_q;
    stab_d     = stab_q;
    req_push_o = 1'b0;
    req_o.op    = (pos_q == MassFirst) ? REQ_MASS_FIRST : REQ_MASS;
    req_o.cls   = classify_byte(rx_byte_i);
    req_o.digit = rx_byte_i[3:0];
    req_o.stab  = stab_q;
    if (accept) begin
      if (pos_q == PosW'(0)) begin
        hdr_d = (rx_byte_i == ChS);
      end else if (pos_q == PosW'(1)) begin
        hdr_d = hdr_q & (rx_byte_i == ChU);
      end else if (pos_q == PosW'(2)) begin
        hdr_d = hdr_q & (rx_byte_i == ChI);
      end else if (pos_q == PosW'(3)) begin
        stab_d = classify_stab(rx_byte_i);
      end else if (in_mass) begin
        req_push_o = 1'b1;
      end
      pos_d = pos_inc;
      // last byte of a frame never lies in the mass field
      if (pos_inc >= FrameLen) begin
        pos_d = '0;
        if (hdr_q) begin
          req_push_o = 1'b1;
          req_o.op   = REQ_EMIT;
        end
      end
      if (rx_byte_i == ChLf) begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hdr_q  <= 1'b1;
      stab_q <= STAB_STABLE;
    end else begin
      pos_q  <= pos_d;
      hdr_q  <= hdr_d;
      stab_q <= stab_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < FrameLen)
    else $error("byte position beyond frame");

  a_lf_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_byte_i == ChLf) |=> pos_q == '0)
    else $error("line feed did not resync");

  a_emit_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_push_o && req_o.op == REQ_EMIT) |-> hdr_q && pos_inc == FrameLen)
    else $error("emit request without complete SUI frame");

endmodule

/* sv/srfp_back.sv */
// ----------------------------------------------------------------------------
// srfp_back: mass field parser and result builder
// Runs the number parser on each mass byte and builds the result on emit.
// ----------------------------------------------------------------------------
module srfp_back
  import srfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  srfp_req_t req_i,
  input  logic      req_empty_i,
  output logic      req_pop_o,
  output logic      res_push_o,
  output srfp_res_t res_o,
  input  logic      res_full_i
);

  localparam logic [1:0] PhLead = 2'd0;
  localparam logic [1:0] PhInt  = 2'd1;
  localparam logic [1:0] PhFrac = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  localparam logic [FracW-1:0] FracMax = '1;

  logic [1:0]       phase_q, phase_d, phase_b;
  logic             neg_q, neg_d, neg_b;
  logic [AccW-1:0]  acc_q, acc_d, acc_b;
  logic [FracW-1:0] frac_q, frac_d, frac_b;
  logic             seen_q, seen_d, seen_b;
  logic             is_emit, do_mass;
  logic [AccW+3:0]  acc_x10;
  logic [AccW-1:0]  acc_add;
  logic [MantW-1:0] mag;

  assign is_emit    = (req_i.op == REQ_EMIT);
  assign req_pop_o  = ~req_empty_i & ~(is_emit & res_full_i);
  assign res_push_o = ~req_empty_i & is_emit & ~res_full_i;
  assign do_mass    = req_pop_o & ~is_emit;

  // first mass byte starts from a clean parser
  always_comb begin
    if (req_i.op == REQ_MASS_FIRST) begin
      phase_b = PhLead;
      neg_b   = 1'b0;
      acc_b   = '0;
      frac_b  = '0;
      seen_b  = 1'b0;
    end else begin
      phase_b = phase_q;
      neg_b   = neg_q;
      acc_b   = acc_q;
      frac_b  = frac_q;
      seen_b  = seen_q;
    end
  end

  // saturating acc*10 + digit
  assign acc_x10 = {1'b0, acc_b, 3'b000} + {3'b000, acc_b, 1'b0} +
                   (AccW+4)'(req_i.digit);
  assign acc_add = (acc_x10[AccW+3:AccW] != '0) ? '1 : acc_x10[AccW-1:0];

  always_comb begin
    phase_d = phase_b;
    neg_d   = neg_b;
    acc_d   = acc_b;
    frac_d  = frac_b;
    seen_d  = seen_b;
    unique case (phase_b)
      PhLead: begin
        case (req_i.cls) inside
          CLS_SPACE: phase_d = PhLead;
          CLS_PLUS, CLS_MINUS: begin
            neg_d   = (req_i.cls == CLS_MINUS);
            phase_d = PhInt;
          end
          CLS_DIGIT: begin
            acc_d   = acc_add;
            seen_d  = 1'b1;
            phase_d = PhInt;
          end
          CLS_POINT: phase_d = PhFrac;
          default:   phase_d = PhDone;
        endcase
      end
      PhInt: begin
        if (req_i.cls == CLS_DIGIT) begin
          acc_d  = acc_add;
          seen_d = 1'b1;
        end else if (req_i.cls == CLS_POINT) begin
          phase_d = PhFrac;
        end else begin
          phase_d = PhDone;
        end
      end
      PhFrac: begin
        if (req_i.cls == CLS_DIGIT) begin
          acc_d  = acc_add;
          seen_d = 1'b1;
          if (frac_b != FracMax) frac_d = frac_b + FracW'(1);
        end else begin
          phase_d = PhDone;
        end
      end
      default: phase_d = PhDone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      frac_q  <= '0;
      seen_q  <= 1'b0;
    end else if (do_mass) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      seen_q  <= seen_d;
    end
  end

  assign mag = {1'b0, acc_q};

  always_comb begin
    res_o.stability_class = req_i.stab;
    res_o.mass_valid      = seen_q;
    res_o.fraction_digits = seen_q ? frac_q : '0;
    if (!seen_q) res_o.mass_mantissa = '0;
    else if (neg_q) res_o.mass_mantissa = -$signed(mag);
    else res_o.mass_mantissa = $signed(mag);
  end

  a_clear_when_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (acc_q == '0 && frac_q == '0))
    else $error("accumulator dirty without digits");

  a_emit_holds_parser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (acc_q == $past(acc_q) && seen_q == $past(seen_q)))
    else $error("emit changed parser state");

  a_no_double_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push_o && do_mass))
    else $error("emit and parse in one cycle");

endmodule

/* sv/scale_reading_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// scale_reading_frame_parser_unit: serial scale reading frame parser
// Assembles SUI reading frames from received bytes and reports mass and
// stability class for each complete frame with a valid header.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock; full rises only when results back up.
// Path: a frame's last byte passes the front stage, then the back stage
//   through a 2-entry request queue, then the result queue, before empty falls.
// Result queue holds 2 results; request queue holds 2 requests.
// Reset (rst_ni low, async) empties both queues, sets position to 0,
//   header match to 1 and the parser to its leading-spaces phase.
module scale_reading_frame_parser_unit
  import srfp_pkg::*;
#(
  parameter int MASS_CHARS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              rx_byte_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [MantW-1:0] mass_mantissa_o,
  output logic [FracW-1:0]        fraction_digits_o,
  output logic                    mass_valid_o,
  output logic [2:0]              stability_class_o
);

  srfp_req_t req_in, req_out;
  srfp_res_t res_in, res_out;
  logic      req_push, req_full, req_pop, req_empty;
  logic      res_push, res_full;

  srfp_front #(
    .MASS_CHARS(MASS_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .req_push_o (req_push),
    .req_o      (req_in),
    .req_full_i (req_full)
  );

  srfp_fifo #(
    .WIDTH($bits(srfp_req_t)),
    .DEPTH(2)
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .data_i  (req_in),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .data_o  (req_out),
    .empty_o (req_empty)
  );

  srfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_out),
    .req_empty_i (req_empty),
    .req_pop_o   (req_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  srfp_fifo #(
    .WIDTH($bits(srfp_res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign mass_mantissa_o   = res_out.mass_mantissa;
  assign fraction_digits_o = res_out.fraction_digits;
  assign mass_valid_o      = res_out.mass_valid;
  assign stability_class_o = res_out.stability_class;

endmodule
